/* hw/rtl/prp_pkg.sv */
// Package for the point rotate and project block: widths, fixed constants
// and the configuration register codes. Depends on nothing.
package prp_pkg;

  localparam int COORD_W  = 11;
  localparam int SIZE_W   = 9;
  localparam int COEF_W   = 16;
  localparam int ROW_W    = 48;
  localparam int PROD_W   = COEF_W + COORD_W;
  localparam int ACC_W    = 29;
  localparam int FRAC_W   = 14;
  localparam int DEN_W    = 28;
  localparam int QUO_W    = 17;
  localparam int NUM_W    = DEN_W + QUO_W;
  localparam int CFG_IDX_W = 3;
  localparam int POS_W    = 19;

  localparam int DEPTH_BIAS = 300;
  localparam int PROJ_GAIN  = 75;
  localparam int PROJ_NEAR  = 5;
  localparam int RAD_GAIN   = 12;
  localparam int RAD_NEAR   = 12;
  localparam int RAD_BASE   = 2;
  localparam int RAD_MAX    = 511;
  localparam int EDGE_LOW   = 5;
  localparam int EDGE_HIGH  = 6;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROT_ROW0      = 3'd0,
    REG_ROT_ROW1      = 3'd1,
    REG_ROT_ROW2      = 3'd2,
    REG_SHIFT_X       = 3'd3,
    REG_SHIFT_Y       = 3'd4,
    REG_SHIFT_Z       = 3'd5,
    REG_SCREEN_WIDTH  = 3'd6,
    REG_SCREEN_HEIGHT = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic                     valid;
    logic [SIZE_W-1:0]        size;
    logic signed [ACC_W-1:0]  rx;
    logic signed [ACC_W-1:0]  ry;
    logic signed [ACC_W-1:0]  rz;
  } rot_out_t;

endpackage

/* hw/rtl/prp_rotate.sv */
// Two pipeline stages: nine coefficient products, then the row sums with
// the offsets and depth bias. Depends on prp_pkg.
module prp_rotate (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  input  logic signed [prp_pkg::COORD_W-1:0] px,
  input  logic signed [prp_pkg::COORD_W-1:0] py,
  input  logic signed [prp_pkg::COORD_W-1:0] pz,
  input  logic [prp_pkg::SIZE_W-1:0]         size,
  input  logic [prp_pkg::ROW_W-1:0]          row0,
  input  logic [prp_pkg::ROW_W-1:0]          row1,
  input  logic [prp_pkg::ROW_W-1:0]          row2,
  input  logic signed [prp_pkg::COORD_W-1:0] shift_x,
  input  logic signed [prp_pkg::COORD_W-1:0] shift_y,
  input  logic signed [prp_pkg::COORD_W-1:0] shift_z,
  output prp_pkg::rot_out_t                  rot
);
  import prp_pkg::*;

  logic signed [PROD_W-1:0] prod_r [9];
  logic signed [PROD_W-1:0] prod_nxt [9];
  logic                     v1_r;
  logic [SIZE_W-1:0]        size1_r;
  rot_out_t                 rot_r;
  rot_out_t                 rot_nxt;
  logic [ROW_W-1:0]         rows [3];
  logic signed [COORD_W-1:0] pts [3];

  assign rows[0] = row0;
  assign rows[1] = row1;
  assign rows[2] = row2;
  assign pts[0] = px;
  assign pts[1] = py;
  assign pts[2] = pz;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        prod_nxt[r*3+c] = PROD_W'($signed(rows[r][c*COEF_W +: COEF_W])) *
                          PROD_W'(pts[c]);
      end
    end
  end

  always_comb begin
    rot_nxt.valid = v1_r;
    rot_nxt.size  = size1_r;
    rot_nxt.rx = ACC_W'(prod_r[0]) + ACC_W'(prod_r[1]) + ACC_W'(prod_r[2])
               + (ACC_W'(shift_x) <<< FRAC_W);
    rot_nxt.ry = ACC_W'(prod_r[3]) + ACC_W'(prod_r[4]) + ACC_W'(prod_r[5])
               + (ACC_W'(shift_y) <<< FRAC_W);
    rot_nxt.rz = ACC_W'(prod_r[6]) + ACC_W'(prod_r[7]) + ACC_W'(prod_r[8])
               + ((ACC_W'(shift_z) + ACC_W'(DEPTH_BIAS)) <<< FRAC_W);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      rot_r.valid <= 1'b0;
    end else begin
      v1_r        <= in_valid;
      rot_r.valid <= rot_nxt.valid;
    end
    for (int i = 0; i < 9; i++) prod_r[i] <= prod_nxt[i];
    size1_r    <= size;
    rot_r.size <= rot_nxt.size;
    rot_r.rx   <= rot_nxt.rx;
    rot_r.ry   <= rot_nxt.ry;
    rot_r.rz   <= rot_nxt.rz;
  end

  assign rot = rot_r;

endmodule

/* hw/rtl/prp_div_pipe.sv */
// Pipelined unsigned restoring divider, one quotient bit per stage. The
// caller guarantees num < den * 2**QW. Depends on nothing.
module prp_div_pipe #(
  parameter int DW = 28,
  parameter int QW = 17
) (
  input  logic             clk,
  input  logic [DW+QW-1:0] num,
  input  logic [DW-1:0]    den,
  output logic [QW-1:0]    quo
);

  logic [DW-1:0] rem_r [QW];
  logic [QW-1:0] low_r [QW];
  logic [QW-1:0] quo_r [QW];
  logic [DW-1:0] den_r [QW];

  for (genvar k = 0; k < QW; k++) begin : g_step
    logic [DW-1:0] rem_in;
    logic [QW-1:0] low_in;
    logic [QW-1:0] quo_in;
    logic [DW-1:0] den_in;
    logic [DW:0]   trial;
    logic          take;

    if (k == 0) begin : g_first
      assign rem_in = num[DW+QW-1:QW];
      assign low_in = num[QW-1:0];
      assign quo_in = '0;
      assign den_in = den;
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign low_in = low_r[k-1];
      assign quo_in = quo_r[k-1];
      assign den_in = den_r[k-1];
    end

    assign trial = {rem_in, low_in[QW-1]};
    assign take  = (trial >= {1'b0, den_in});

    always_ff @(posedge clk) begin
      rem_r[k] <= take ? DW'(trial - {1'b0, den_in}) : trial[DW-1:0];
      low_r[k] <= low_in << 1;
      quo_r[k] <= {quo_in[QW-2:0], take};
      den_r[k] <= den_in;
    end
  end

  assign quo = quo_r[QW-1];

endmodule

/* hw/rtl/point_rotate_project.sv */
// Point rotate and project: throughput one point per cycle; busy is always
// low. The rotation stages come first, then the stage that forms the
// dividends, then the divider stages and the final stage, which drives out_strobe.
// rst_n is synchronous and active low: it clears the valid bits of the
// pipeline and loads the identity matrix, zero offsets and a 640x480 screen.
// The receiver cannot stall, so the pipeline advances on every clock.
module point_rotate_project (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [prp_pkg::COORD_W-1:0] in_point_x,
  input  logic signed [prp_pkg::COORD_W-1:0] in_point_y,
  input  logic signed [prp_pkg::COORD_W-1:0] in_point_z,
  input  logic [prp_pkg::SIZE_W-1:0]         in_point_size,
  output logic                               out_strobe,
  output logic [10:0]                        out_screen_col,
  output logic [10:0]                        out_screen_row,
  output logic [8:0]                         out_disk_radius,
  output logic                               out_visible,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [prp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [prp_pkg::ROW_W-1:0]          cfg_data
);
  import prp_pkg::*;

  // Configuration registers. The user must send writes only while the pipeline
  // is empty; the block does not enforce it. Later stages read these directly.
  logic [ROW_W-1:0]          row0_r, row1_r, row2_r;
  logic signed [COORD_W-1:0] shift_x_r, shift_y_r, shift_z_r;
  logic [COORD_W-1:0]        width_r, height_r;

  assign cfg_ready = 1'b1;
  assign busy      = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row0_r    <= ROW_W'(64'd16384);
      row1_r    <= ROW_W'(64'd16384 << 16);
      row2_r    <= ROW_W'(64'd16384 << 32);
      shift_x_r <= '0;
      shift_y_r <= '0;
      shift_z_r <= '0;
      width_r   <= COORD_W'(640);
      height_r  <= COORD_W'(480);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_ROT_ROW0:      row0_r    <= cfg_data;
        REG_ROT_ROW1:      row1_r    <= cfg_data;
        REG_ROT_ROW2:      row2_r    <= cfg_data;
        REG_SHIFT_X:       shift_x_r <= cfg_data[COORD_W-1:0];
        REG_SHIFT_Y:       shift_y_r <= cfg_data[COORD_W-1:0];
        REG_SHIFT_Z:       shift_z_r <= cfg_data[COORD_W-1:0];
        REG_SCREEN_WIDTH:  width_r   <= cfg_data[COORD_W-1:0];
        REG_SCREEN_HEIGHT: height_r  <= cfg_data[COORD_W-1:0];
        default: ;
      endcase
    end
  end

  // Stages one and two: the rotation with offsets and depth bias, in Q.14.
  rot_out_t rot;

  prp_rotate u_rotate (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (start && !busy),
    .px       (in_point_x),
    .py       (in_point_y),
    .pz       (in_point_z),
    .size     (in_point_size),
    .row0     (row0_r),
    .row1     (row1_r),
    .row2     (row2_r),
    .shift_x  (shift_x_r),
    .shift_y  (shift_y_r),
    .shift_z  (shift_z_r),
    .rot      (rot)
  );

  // Stage three: the projection divides magnitudes, so the signs of rx and
  // ry travel beside the dividers. The depth test is taken here as well.
  localparam logic signed [ACC_W-1:0] NEAR_Q = ACC_W'(PROJ_NEAR << FRAC_W);
  localparam logic signed [ACC_W-1:0] RNEAR_Q = ACC_W'(RAD_NEAR << FRAC_W);

  logic [ACC_W-1:0] abs_x, abs_y;
  logic [NUM_W-1:0] num_x_r, num_y_r, num_r_r;
  logic [DEN_W-1:0] den_p_r, den_r_r;
  logic             v3_r, front3_r, sx3_r, sy3_r;

  assign abs_x = rot.rx[ACC_W-1] ? ACC_W'(-rot.rx) : ACC_W'(rot.rx);
  assign abs_y = rot.ry[ACC_W-1] ? ACC_W'(-rot.ry) : ACC_W'(rot.ry);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= rot.valid;
    end
    front3_r <= (rot.rz > NEAR_Q);
    sx3_r    <= rot.rx[ACC_W-1];
    sy3_r    <= rot.ry[ACC_W-1];
    num_x_r  <= NUM_W'(abs_x) * NUM_W'(PROJ_GAIN);
    num_y_r  <= NUM_W'(abs_y) * NUM_W'(PROJ_GAIN);
    num_r_r  <= (NUM_W'(rot.size) * NUM_W'(RAD_GAIN)) << FRAC_W;
    den_p_r  <= DEN_W'(rot.rz + NEAR_Q);
    den_r_r  <= DEN_W'(rot.rz + RNEAR_Q);
  end

  // Three dividers in step with one another. A point that fails the depth
  // test may present a zero divisor; its quotients are discarded.
  logic [QUO_W-1:0] qx, qy, qr;

  prp_div_pipe #(.DW(DEN_W), .QW(QUO_W)) u_div_x (
    .clk (clk), .num (num_x_r), .den (den_p_r), .quo (qx)
  );
  prp_div_pipe #(.DW(DEN_W), .QW(QUO_W)) u_div_y (
    .clk (clk), .num (num_y_r), .den (den_p_r), .quo (qy)
  );
  prp_div_pipe #(.DW(DEN_W), .QW(QUO_W)) u_div_r (
    .clk (clk), .num (num_r_r), .den (den_r_r), .quo (qr)
  );

  // Side line for the valid bit, the depth test and the two signs.
  logic [3:0] side_r [QUO_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < QUO_W; i++) side_r[i][0] <= 1'b0;
    end else begin
      side_r[0][0] <= v3_r;
      for (int i = 1; i < QUO_W; i++) side_r[i][0] <= side_r[i-1][0];
    end
    side_r[0][3:1] <= {sy3_r, sx3_r, front3_r};
    for (int i = 1; i < QUO_W; i++) side_r[i][3:1] <= side_r[i-1][3:1];
  end

  // Final stage: restore the signs, centre on the screen, test the border
  // margins and saturate the radius. Position and radius are zero when not visible.
  logic signed [POS_W-1:0] col_s, row_s, wlim, hlim;
  logic [QUO_W:0]          rad_s;
  logic                    in_margin, vis;
  logic                    strobe_r, vis_r;
  logic [10:0]             col_r, row_o_r;
  logic [8:0]              rad_r;

  always_comb begin
    col_s = side_r[QUO_W-1][2] ? -POS_W'(qx) : POS_W'(qx);
    row_s = side_r[QUO_W-1][3] ? -POS_W'(qy) : POS_W'(qy);
    col_s = col_s + POS_W'(width_r >> 1);
    row_s = row_s + POS_W'(height_r >> 1);
    wlim  = POS_W'(width_r) - POS_W'(EDGE_HIGH);
    hlim  = POS_W'(height_r) - POS_W'(EDGE_HIGH);
    in_margin = (col_s > POS_W'(EDGE_LOW)) && (col_s < wlim) &&
                (row_s > POS_W'(EDGE_LOW)) && (row_s < hlim);
    vis   = side_r[QUO_W-1][1] && in_margin;
    rad_s = (QUO_W+1)'(qr) + (QUO_W+1)'(RAD_BASE);
    if (rad_s > (QUO_W+1)'(RAD_MAX)) rad_s = (QUO_W+1)'(RAD_MAX);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
      vis_r    <= 1'b0;
    end else begin
      strobe_r <= side_r[QUO_W-1][0];
      vis_r    <= side_r[QUO_W-1][0] && vis;
    end
    col_r   <= vis ? col_s[10:0] : '0;
    row_o_r <= vis ? row_s[10:0] : '0;
    rad_r   <= vis ? rad_s[8:0] : '0;
  end

  assign out_strobe      = strobe_r;
  assign out_visible     = vis_r;
  assign out_screen_col  = col_r;
  assign out_screen_row  = row_o_r;
  assign out_disk_radius = rad_r;

  // A visible point is always a strobed beat with a base radius at least.
  a_vis_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_visible |-> out_strobe)
    else $error("visible without strobe");
  a_hidden_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_visible) |->
      (out_screen_col == '0 && out_screen_row == '0 && out_disk_radius == '0))
    else $error("hidden point with non-zero fields");
  a_rad_base: assert property (@(posedge clk) disable iff (!rst_n)
    out_visible |-> (out_disk_radius >= 9'(RAD_BASE)))
    else $error("visible radius below base");
  a_col_margin: assert property (@(posedge clk) disable iff (!rst_n)
    out_visible |-> (out_screen_col > 11'(EDGE_LOW) && out_screen_row > 11'(EDGE_LOW)))
    else $error("visible point inside the margin");

endmodule
